/* sv/lir_pkg.sv */
// ----------------------------------------------------------------------------
// lir_pkg
// Shared widths, register indexes and types of the linear interpolation
// resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int RATE_W    = 20;
   localparam int CFG_W     = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* sv/linear_interp_resampler_unit.sv */
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Linear interpolation resampler with an exact rational source phase.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit sample per req transaction and gives the
// interpolated samples that it completes on rsp, tlast on the final one of
// that input and tuser on the final output of the buffer. All products and
// quotients come from one multiplier and one restoring divider that yields
// one quotient bit per cycle, DW = max(COUNT_BITS + 20, 36) bits per division
// (44 at the defaults). An input takes two divisions of setup (output count
// and rate ratio) plus one division for each result it produces, and waits
// while rsp stalls; an empty buffer or disabled rates skip the divisions.
// req_tready is low while an input is in work and rises again once the block
// is back in idle; csr writes are taken while the block is idle, and writes to
// the rate and count registers restart the buffer.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit import lir_pkg::*; #(
   parameter int COUNT_BITS     = 24,
   parameter int MAX_OUT_PER_IN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,   // [15:0] out_sample
   output logic                 rsp_tlast,
   output logic                 rsp_tuser,   // [0] buffer_done
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int CB = COUNT_BITS;
   localparam int TW = CB + 6;
   localparam int DW = (CB + 20 > 36) ? CB + 20 : 36;
   localparam int MA = ((CB > 17) ? CB : 17) + 1;
   localparam int PW = MA + RATE_W + 1;
   localparam int NW = $clog2(MAX_OUT_PER_IN + 1);
   localparam int EW = RATE_W + 7;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_START  = 4'd1;
   localparam logic [3:0] ST_TOT    = 4'd2;
   localparam logic [3:0] ST_TOTW   = 4'd3;
   localparam logic [3:0] ST_QW     = 4'd4;
   localparam logic [3:0] ST_CHECK  = 4'd5;
   localparam logic [3:0] ST_M0     = 4'd6;
   localparam logic [3:0] ST_M1     = 4'd7;
   localparam logic [3:0] ST_ADD    = 4'd8;
   localparam logic [3:0] ST_DIV    = 4'd9;
   localparam logic [3:0] ST_DIVW   = 4'd10;
   localparam logic [3:0] ST_PUSH   = 4'd11;
   localparam logic [3:0] ST_FINISH = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [RATE_W-1:0]   in_rate_ff, in_rate_in;
   logic [RATE_W-1:0]   out_rate_ff, out_rate_in;
   logic [CFG_W-1:0]    count_ff, count_in;
   logic [CB-1:0]       k_ff, k_in;
   logic [TW-1:0]       oidx_ff, oidx_in;
   logic [CB-1:0]       whole_ff, whole_in;
   logic [RATE_W-1:0]   rem_ff, rem_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [NW-1:0]       n_ff, n_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [SAMPLE_W-1:0]        cur_ff, cur_in;
   logic signed [SAMPLE_W-1:0] s0_ff, s0_in;
   logic signed [SAMPLE_W-1:0] s1_ff, s1_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic signed [PW-1:0]       acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic [TW-1:0]              total_ff, total_in;
   logic [CB-1:0]              q_ff, q_in;
   logic [RATE_W-1:0]          r0_ff, r0_in;
   logic [SAMPLE_W-1:0]        pend_data_ff, pend_data_in;
   logic                       pend_done_ff, pend_done_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_user_ff, rsp_user_in;

   logic                 div_start;
   logic [DW-1:0]        div_dividend;
   logic [RATE_W-1:0]    div_divisor;
   logic [DW-1:0]        div_quotient;
   logic [RATE_W-1:0]    div_remainder;
   div_stat_type         div_stat;

   logic signed [MA-1:0]     mul_a;
   logic signed [RATE_W:0]   mul_b;
   logic signed [PW-1:0]     mul_p;
   logic signed [SAMPLE_W:0] diff;

   logic [31:0]         cnt_ext;
   logic [CB-1:0]       count_w;
   logic [EW-1:0]       rate_lim;
   logic                enabled;
   logic                final_w;
   logic                rsp_free;
   logic                sat;
   logic [SAMPLE_W-1:0] res_val;
   logic [RATE_W:0]     t_sum;
   logic                carry;
   logic [CB:0]         k_next;
   logic [PW-1:0]       acc_abs;
   logic                restart;

   lir_div #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_stat)
   );

   assign cnt_ext  = {8'd0, count_ff};
   assign count_w  = cnt_ext[CB-1:0];
   assign rate_lim = EW'(in_rate_ff) * EW'(MAX_OUT_PER_IN);
   assign enabled  = (in_rate_ff != '0) && (out_rate_ff != '0)
                     && (EW'(out_rate_ff) <= rate_lim);
   assign final_w  = (k_ff == count_w - CB'(1));
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign diff     = $signed({s1_ff[SAMPLE_W-1], s1_ff}) - $signed({s0_ff[SAMPLE_W-1], s0_ff});
   assign mul_p    = mul_a * mul_b;
   assign acc_abs  = acc_ff[PW-1] ? (~acc_ff + PW'(1)) : acc_ff;
   assign t_sum    = {1'b0, rem_ff} + {1'b0, r0_ff};
   assign carry    = t_sum >= {1'b0, out_rate_ff};
   assign k_next   = {1'b0, k_ff} + (CB + 1)'(1);
   assign div_divisor = (state_ff == ST_TOT) ? in_rate_ff : out_rate_ff;

   always_comb begin
      sat = neg_ff ? (div_quotient > DW'(32768)) : (div_quotient > DW'(32767));
      if (sat) begin
         res_val = neg_ff ? SAMPLE_MIN : SAMPLE_MAX;
      end else if (neg_ff) begin
         res_val = ~div_quotient[SAMPLE_W-1:0] + SAMPLE_W'(1);
      end else begin
         res_val = div_quotient[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_START: begin
            mul_a = MA'($signed({1'b0, count_w}));
            mul_b = $signed({1'b0, out_rate_ff});
         end
         ST_M0: begin
            mul_a = MA'(s0_ff);
            mul_b = $signed({1'b0, out_rate_ff});
         end
         ST_M1: begin
            mul_a = MA'(diff);
            mul_b = $signed({1'b0, rem_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      in_rate_in    = in_rate_ff;
      out_rate_in   = out_rate_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      oidx_in       = oidx_ff;
      whole_in      = whole_ff;
      rem_in        = rem_ff;
      prev_in       = prev_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      cur_in        = cur_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      total_in      = total_ff;
      q_in          = q_ff;
      r0_in         = r0_ff;
      pend_data_in  = pend_data_ff;
      pend_done_in  = pend_done_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_user_in   = rsp_user_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      restart       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cur_in   = req_tdata;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (count_w == '0) begin
               prev_in  = cur_ff;
               restart  = 1'b1;
               state_in = ST_IDLE;
            end else if (!enabled) begin
               state_in = ST_FINISH;
            end else begin
               prod_in  = mul_p;
               state_in = ST_TOT;
            end
         end
         ST_TOT: begin
            div_start    = 1'b1;
            div_dividend = prod_ff[DW-1:0];
            state_in     = ST_TOTW;
         end
         ST_TOTW: begin
            if (div_stat.done) begin
               total_in     = div_quotient[TW-1:0];
               div_start    = 1'b1;
               div_dividend = DW'(in_rate_ff);
               state_in     = ST_QW;
            end
         end
         ST_QW: begin
            if (div_stat.done) begin
               q_in     = div_quotient[CB-1:0];
               r0_in    = div_remainder;
               n_in     = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_FINISH;
            if (n_ff < NW'(MAX_OUT_PER_IN) && oidx_ff < total_ff) begin
               if (k_ff != '0 && whole_ff == k_ff - CB'(1)) begin
                  s0_in    = prev_ff;
                  s1_in    = cur_ff;
                  state_in = ST_M0;
               end else if (final_w && whole_ff == k_ff) begin
                  s0_in    = cur_ff;
                  s1_in    = cur_ff;
                  state_in = ST_M0;
               end
            end
         end
         ST_M0: begin
            prod_in  = mul_p;
            state_in = ST_M1;
         end
         ST_M1: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_start    = 1'b1;
            div_dividend = acc_abs[DW-1:0];
            neg_in       = acc_ff[PW-1];
            state_in     = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_stat.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!pend_valid_ff || rsp_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_data_ff;
                  rsp_last_in  = 1'b0;
                  rsp_user_in  = pend_done_ff;
               end
               pend_valid_in = 1'b1;
               pend_data_in  = res_val;
               pend_done_in  = (oidx_ff + TW'(1) == total_ff);
               oidx_in       = oidx_ff + TW'(1);
               rem_in        = carry ? RATE_W'(t_sum - {1'b0, out_rate_ff})
                                     : t_sum[RATE_W-1:0];
               whole_in      = whole_ff + q_ff + CB'(carry);
               n_in          = n_ff + NW'(1);
               state_in      = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || rsp_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_data_ff;
                  rsp_last_in  = 1'b1;
                  rsp_user_in  = pend_done_ff || final_w;
               end
               pend_valid_in = 1'b0;
               prev_in       = cur_ff;
               k_in          = k_next[CB-1:0];
               if (k_next >= {1'b0, count_w}) begin
                  restart = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && state_ff == ST_IDLE) begin
         unique case (csr_index)
            REG_INPUT_RATE: begin
               in_rate_in = csr_data[RATE_W-1:0];
               restart    = 1'b1;
            end
            REG_OUTPUT_RATE: begin
               out_rate_in = csr_data[RATE_W-1:0];
               restart     = 1'b1;
            end
            REG_SAMPLE_COUNT: begin
               count_in = csr_data;
               restart  = 1'b1;
            end
            default: begin
               restart = restart;
            end
         endcase
      end

      if (restart) begin
         k_in     = '0;
         oidx_in  = '0;
         whole_in = '0;
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_rate_ff    <= RATE_W'(1);
         out_rate_ff   <= RATE_W'(1);
         count_ff      <= '0;
         k_ff          <= '0;
         oidx_ff       <= '0;
         whole_ff      <= '0;
         rem_ff        <= '0;
         prev_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_rate_ff    <= in_rate_in;
         out_rate_ff   <= out_rate_in;
         count_ff      <= count_in;
         k_ff          <= k_in;
         oidx_ff       <= oidx_in;
         whole_ff      <= whole_in;
         rem_ff        <= rem_in;
         prev_ff       <= prev_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      s0_ff        <= s0_in;
      s1_ff        <= s1_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      total_ff     <= total_in;
      q_ff         <= q_in;
      r0_ff        <= r0_in;
      pend_data_ff <= pend_data_in;
      pend_done_ff <= pend_done_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* sv/lir_div.sv */
// ----------------------------------------------------------------------------
// lir_div
// Restoring divider, one quotient bit per cycle, shared by the resampler
// for buffer length, rate ratio and interpolation divisions.
// ----------------------------------------------------------------------------
module lir_div import lir_pkg::*; #(
   parameter int DW = 44
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     dividend,
   input  logic [RATE_W-1:0] divisor,
   output logic [DW-1:0]     quotient,
   output logic [RATE_W-1:0] remainder,
   output div_stat_type      status
);

   localparam int CW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] div_ff, div_in;

   logic [RATE_W:0] trial;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      ge      = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? RATE_W'(trial - {1'b0, div_ff}) : trial[RATE_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
